// ===== rtl/hsl2rgb_pkg.sv =====
package hsl2rgb_pkg;

  localparam logic [10:0] TURN      = 11'd1536;
  localparam logic [8:0]  ONE_Q8    = 9'd256;
  localparam logic [8:0]  HALF_Q8   = 9'd128;
  localparam logic [9:0]  TWO_Q8    = 10'd512;
  localparam logic [10:0] BOUND_1   = 11'd256;
  localparam logic [10:0] BOUND_2   = 11'd512;
  localparam logic [10:0] BOUND_3   = 11'd768;
  localparam logic [10:0] BOUND_4   = 11'd1024;
  localparam logic [10:0] BOUND_5   = 11'd1280;
  localparam int          VW        = 25;
  localparam logic [VW-1:0] HALF_Q24 = 25'h0800000;
  localparam logic [VW-1:0] ONE_Q24  = 25'h1000000;

  // hue sectors, named by the channel pair they span
  typedef enum logic [2:0] {
    SEC_RY,
    SEC_YG,
    SEC_GC,
    SEC_CB,
    SEC_BM,
    SEC_MR
  } sector_t;

  typedef struct packed {
    sector_t     sector;
    logic [8:0]  frac;
    logic [8:0]  light;
    logic [16:0] chroma;
  } s1_t;

  typedef struct packed {
    sector_t       sector;
    logic [VW-1:0] prod;
    logic [16:0]   lo;
    logic [16:0]   hi;
  } s2_t;

  typedef struct packed {
    logic [VW-1:0] r;
    logic [VW-1:0] g;
    logic [VW-1:0] b;
  } s3_t;

endpackage

// ===== rtl/hsl2rgb_in_if.sv =====
interface hsl2rgb_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] hue;
  logic [8:0]  saturation;
  logic [8:0]  lightness;

  modport source (output valid, output hue, output saturation, output lightness, input ready);
  modport sink (input valid, input hue, input saturation, input lightness, output ready);
endinterface

// ===== rtl/hsl2rgb_out_if.sv =====
interface hsl2rgb_out_if #(
  parameter int OUT_BITS = 8
);
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] red;
  logic [OUT_BITS-1:0] green;
  logic [OUT_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/hsl_to_rgb_converter.sv =====
// HSL to RGB pixel converter. Hue is in sextants times 256 (1536 is one
// turn, larger codes wrap), saturation and lightness use 256 as 1.0 and
// clamp above it. Each channel comes out as floor(x * (2^OUT_BITS - 1) + 0.5).
// One pixel per clock is accepted and delivered while the output is not
// stalled. A beat passes through one register stage for each step: range
// reduction and chroma multiply, min/max levels and hue-fraction multiply,
// sector mux, and rounding into the output register. Each stage holds its
// beat on a stall and takes a new one as soon as it empties, so bubbles
// close up and no beat is lost or repeated.
module hsl_to_rgb_converter
  import hsl2rgb_pkg::*;
#(
  parameter int OUT_BITS = 8
) (
  input logic            clk,
  input logic            rst_n,
  hsl2rgb_in_if.sink     in_ch,
  hsl2rgb_out_if.source  out_ch
);

  logic s1_v;
  logic s1_rdy;
  s1_t  s1_q;
  logic s2_v;
  logic s2_rdy;
  s2_t  s2_q;
  logic s3_v;
  logic s3_rdy;
  s3_t  s3_q;

  hsl2rgb_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .hue        (in_ch.hue),
    .saturation (in_ch.saturation),
    .lightness  (in_ch.lightness),
    .out_valid  (s1_v),
    .out_ready  (s1_rdy),
    .out_data   (s1_q)
  );

  hsl2rgb_level u_level (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v),
    .in_ready  (s1_rdy),
    .in_data   (s1_q),
    .out_valid (s2_v),
    .out_ready (s2_rdy),
    .out_data  (s2_q)
  );

  hsl2rgb_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_v),
    .in_ready  (s2_rdy),
    .in_data   (s2_q),
    .out_valid (s3_v),
    .out_ready (s3_rdy),
    .out_data  (s3_q)
  );

  hsl2rgb_quant #(
    .OUT_BITS (OUT_BITS)
  ) u_quant (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_v),
    .in_ready  (s3_rdy),
    .in_data   (s3_q),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .red       (out_ch.red),
    .green     (out_ch.green),
    .blue      (out_ch.blue)
  );

  // input only stalls when every stage holds a beat
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v && s2_v && s3_v && out_ch.valid))
    else $error("input stalled with a bubble in the pipe");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v && !s1_rdy) |=> (s1_v && $stable(s1_q)))
    else $error("stage 1 beat changed while stalled");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v && !s2_rdy) |=> (s2_v && $stable(s2_q)))
    else $error("stage 2 beat changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v |-> (s3_q.r <= ONE_Q24 && s3_q.g <= ONE_Q24 && s3_q.b <= ONE_Q24))
    else $error("channel level above full scale");

endmodule

// ===== rtl/hsl2rgb_prep.sv =====
module hsl2rgb_prep
  import hsl2rgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [10:0] hue,
  input  logic [8:0]  saturation,
  input  logic [8:0]  lightness,
  output logic        out_valid,
  input  logic        out_ready,
  output s1_t         out_data
);

  logic        v_r;
  s1_t         q_r;
  s1_t         q_nxt;
  logic [10:0] h;
  logic [8:0]  s;
  logic [8:0]  l;
  logic [9:0]  two_l;
  logic [9:0]  fac;
  logic [10:0] f_wide;

  always_comb begin
    h     = (hue >= TURN) ? hue - TURN : hue;
    s     = (saturation > ONE_Q8) ? ONE_Q8 : saturation;
    l     = (lightness > ONE_Q8) ? ONE_Q8 : lightness;
    two_l = {l, 1'b0};
    fac   = (l <= HALF_Q8) ? two_l : TWO_Q8 - two_l;

    if (h <= BOUND_1) begin
      q_nxt.sector = SEC_RY;
      f_wide       = h;
    end else if (h <= BOUND_2) begin
      q_nxt.sector = SEC_YG;
      f_wide       = BOUND_2 - h;
    end else if (h <= BOUND_3) begin
      q_nxt.sector = SEC_GC;
      f_wide       = h - BOUND_2;
    end else if (h <= BOUND_4) begin
      q_nxt.sector = SEC_CB;
      f_wide       = BOUND_4 - h;
    end else if (h <= BOUND_5) begin
      q_nxt.sector = SEC_BM;
      f_wide       = h - BOUND_4;
    end else begin
      q_nxt.sector = SEC_MR;
      f_wide       = TURN - h;
    end

    q_nxt.frac   = f_wide[8:0];
    q_nxt.light  = l;
    q_nxt.chroma = 17'(s) * 17'(fac[8:0]);
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_r <= q_nxt;
    end
  end

endmodule

// ===== rtl/hsl2rgb_level.sv =====
module hsl2rgb_level
  import hsl2rgb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  s1_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output s2_t  out_data
);

  logic        v_r;
  s2_t         q_r;
  s2_t         q_nxt;
  logic [16:0] base;

  always_comb begin
    base         = {in_data.light, 8'd0};
    q_nxt.sector = in_data.sector;
    q_nxt.prod   = VW'(in_data.frac) * VW'(in_data.chroma);
    q_nxt.lo     = base - {1'b0, in_data.chroma[16:1]};
    q_nxt.hi     = base + {1'b0, in_data.chroma[16:1]};
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_r <= q_nxt;
    end
  end

endmodule

// ===== rtl/hsl2rgb_mix.sv =====
module hsl2rgb_mix
  import hsl2rgb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  s2_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output s3_t  out_data
);

  logic          v_r;
  s3_t           q_r;
  s3_t           q_nxt;
  logic [VW-1:0] lo24;
  logic [VW-1:0] hi24;
  logic [VW-1:0] mid24;

  always_comb begin
    lo24  = {in_data.lo, 8'd0};
    hi24  = {in_data.hi, 8'd0};
    mid24 = in_data.prod + lo24;
    case (in_data.sector)
      SEC_RY: begin
        q_nxt.r = hi24;  q_nxt.g = mid24; q_nxt.b = lo24;
      end
      SEC_YG: begin
        q_nxt.r = mid24; q_nxt.g = hi24;  q_nxt.b = lo24;
      end
      SEC_GC: begin
        q_nxt.r = lo24;  q_nxt.g = hi24;  q_nxt.b = mid24;
      end
      SEC_CB: begin
        q_nxt.r = lo24;  q_nxt.g = mid24; q_nxt.b = hi24;
      end
      SEC_BM: begin
        q_nxt.r = mid24; q_nxt.g = lo24;  q_nxt.b = hi24;
      end
      default: begin
        q_nxt.r = hi24;  q_nxt.g = lo24;  q_nxt.b = mid24;
      end
    endcase
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_r <= q_nxt;
    end
  end

endmodule

// ===== rtl/hsl2rgb_quant.sv =====
module hsl2rgb_quant
  import hsl2rgb_pkg::*;
#(
  parameter int OUT_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  s3_t                 in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_BITS-1:0] red,
  output logic [OUT_BITS-1:0] green,
  output logic [OUT_BITS-1:0] blue
);

  localparam int QW = VW + OUT_BITS;

  logic                v_r;
  logic [OUT_BITS-1:0] red_r;
  logic [OUT_BITS-1:0] green_r;
  logic [OUT_BITS-1:0] blue_r;
  logic [QW-1:0]       r_sc;
  logic [QW-1:0]       g_sc;
  logic [QW-1:0]       b_sc;

  // v * (2^N - 1) + 0.5, then drop the 24 fraction bits
  always_comb begin
    r_sc = (QW'(in_data.r) << OUT_BITS) - QW'(in_data.r) + QW'(HALF_Q24);
    g_sc = (QW'(in_data.g) << OUT_BITS) - QW'(in_data.g) + QW'(HALF_Q24);
    b_sc = (QW'(in_data.b) << OUT_BITS) - QW'(in_data.b) + QW'(HALF_Q24);
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      red_r   <= r_sc[VW-1 +: OUT_BITS];
      green_r <= g_sc[VW-1 +: OUT_BITS];
      blue_r  <= b_sc[VW-1 +: OUT_BITS];
    end
  end

endmodule
